// ===== hw/rtl/tpm_pkg.sv =====
// ----------------------------------------------------------------------------
// tpm_pkg
// Shared types and constants for the prefix tree match scorer.
// ----------------------------------------------------------------------------
package tpm_pkg;

    localparam int ALPHA      = 26;
    localparam int LETTER_W   = 5;
    localparam int SCORE_W    = 23;
    localparam int NCOUNT_W   = 13;

    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;

    localparam logic KIND_WORD = 1'b0;
    localparam logic KIND_CAND = 1'b1;

    typedef struct packed {
        logic                is_lower;
        logic                is_upper;
        logic [LETTER_W-1:0] letter;
    } t_char_class;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_DICT  = 7'b0000100,
        S_WL    = 7'b0001000,
        S_WC    = 7'b0010000,
        S_WN    = 7'b0100000,
        S_MUL   = 7'b1000000
    } t_state;

endpackage

// ===== hw/rtl/tpm_ram.sv =====
// ----------------------------------------------------------------------------
// tpm_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/tpm_char_class.sv =====
// ----------------------------------------------------------------------------
// tpm_char_class
// Classifies a byte as lower or upper case letter and gives its letter index.
// ----------------------------------------------------------------------------
module tpm_char_class
    import tpm_pkg::*;
(
    input  logic [7:0]  i_char,
    output t_char_class o_class
);

    logic is_lower;
    logic is_upper;

    assign is_lower = (i_char >= CH_LOWER_A) && (i_char <= CH_LOWER_Z);
    assign is_upper = (i_char >= CH_UPPER_A) && (i_char <= CH_UPPER_Z);

    always_comb begin
        o_class.is_lower = is_lower;
        o_class.is_upper = is_upper;
        if (is_upper) begin
            o_class.letter = LETTER_W'(i_char - CH_UPPER_A);
        end else begin
            o_class.letter = LETTER_W'(i_char - CH_LOWER_A);
        end
    end

endmodule

// ===== hw/rtl/trie_prefix_match_scorer_top.sv =====
// ----------------------------------------------------------------------------
// trie_prefix_match_scorer_top
// Prefix tree builder and longest-prefix-match scorer around two RAMs.
// Word character: a tree lookup (child RAM read) in DICT when one is needed.
// Candidate character: its letter is stored in the letter RAM; at the last one
// the walk reads the letter RAM, then the child RAM, for each tree step.
// Reset: a clearing pass writes all NODES*26 child entries, with no word
// accepted meanwhile.
// ----------------------------------------------------------------------------
module trie_prefix_match_scorer_top
    import tpm_pkg::*;
#(
    parameter int NODES   = 4096,
    parameter int MAX_LEN = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_kind,
    input  logic [7:0]          i_char_byte,
    input  logic                i_last,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_result_kind,
    output logic [SCORE_W-1:0]  o_score,
    output logic [NCOUNT_W-1:0] o_node_count,
    output logic                o_table_full,
    output logic                o_too_long
);

    localparam int NW  = $clog2(NODES);
    localparam int UW  = $clog2(NODES + 1);
    localparam int TD  = NODES * ALPHA;
    localparam int TAW = $clog2(TD);
    localparam int BAW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW  = $clog2(MAX_LEN + 1);
    localparam int SW  = $clog2(MAX_LEN * MAX_LEN + 1);

    function automatic logic [TAW-1:0] f_addr(input logic [NW-1:0] node,
                                              input logic [LETTER_W-1:0] letter);
        f_addr = TAW'(node) * TAW'(ALPHA) + TAW'(letter);
    endfunction

    t_state r_state, n_state;
    logic [TAW-1:0] r_clr, n_clr;
    logic [TAW-1:0] r_caddr, n_caddr;
    logic           r_last, n_last;
    logic [UW-1:0]  r_nodes_used, n_nodes_used;
    logic [NW-1:0]  r_ins, n_ins;
    logic           r_halted, n_halted;
    logic           r_over, n_over;
    logic [CW-1:0]  r_count, n_count;
    logic           r_trunc, n_trunc;
    logic [BAW-1:0] r_i, n_i;
    logic [BAW-1:0] r_j, n_j;
    logic [NW-1:0]  r_node, n_node;
    logic [SW-1:0]  r_sum, n_sum;

    logic               r_o_valid, n_o_valid;
    logic               r_o_kind, n_o_kind;
    logic [SCORE_W-1:0] r_o_score, n_o_score;
    logic [NCOUNT_W-1:0] r_o_nc, n_o_nc;
    logic               r_o_full, n_o_full;
    logic               r_o_long, n_o_long;

    logic           ct_we;
    logic [TAW-1:0] ct_waddr;
    logic [NW-1:0]  ct_wdata;
    logic [TAW-1:0] ct_raddr;
    logic [NW-1:0]  ct_rdata;

    logic                lb_we;
    logic [BAW-1:0]      lb_waddr;
    logic [BAW-1:0]      lb_raddr;
    logic [LETTER_W-1:0] lb_rdata;

    t_char_class cc;
    logic        in_acc;
    logic        j_last;
    logic        i_is_last;

    tpm_char_class u_cc (
        .i_char  (i_char_byte),
        .o_class (cc)
    );

    tpm_ram #(.WIDTH(NW), .DEPTH(TD)) u_child (
        .i_clk   (i_clk),
        .i_we    (ct_we),
        .i_waddr (ct_waddr),
        .i_wdata (ct_wdata),
        .i_raddr (ct_raddr),
        .o_rdata (ct_rdata)
    );

    tpm_ram #(.WIDTH(LETTER_W), .DEPTH(MAX_LEN)) u_letters (
        .i_clk   (i_clk),
        .i_we    (lb_we),
        .i_waddr (lb_waddr),
        .i_wdata (cc.letter),
        .i_raddr (lb_raddr),
        .o_rdata (lb_rdata)
    );

    assign o_ready   = (r_state == S_IDLE) && (!r_o_valid || i_ready);
    assign in_acc    = i_valid && o_ready;
    assign j_last    = (CW'(r_j) == r_count - CW'(1));
    assign i_is_last = (CW'(r_i) == r_count - CW'(1));

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_caddr      = r_caddr;
        n_last       = r_last;
        n_nodes_used = r_nodes_used;
        n_ins        = r_ins;
        n_halted     = r_halted;
        n_over       = r_over;
        n_count      = r_count;
        n_trunc      = r_trunc;
        n_i          = r_i;
        n_j          = r_j;
        n_node       = r_node;
        n_sum        = r_sum;
        n_o_valid    = r_o_valid && !i_ready;
        n_o_kind     = r_o_kind;
        n_o_score    = r_o_score;
        n_o_nc       = r_o_nc;
        n_o_full     = r_o_full;
        n_o_long     = r_o_long;
        ct_we        = 1'b0;
        ct_waddr     = r_caddr;
        ct_wdata     = '0;
        ct_raddr     = r_caddr;
        lb_we        = 1'b0;
        lb_waddr     = r_count[BAW-1:0];
        lb_raddr     = r_j;

        unique case (r_state)
            S_CLEAR: begin
                ct_we    = 1'b1;
                ct_waddr = r_clr;
                if (r_clr == TAW'(TD - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + TAW'(1);
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    if (i_kind == KIND_WORD) begin
                        if (!r_halted && cc.is_lower) begin
                            n_caddr  = f_addr(r_ins, cc.letter);
                            ct_raddr = n_caddr;
                            n_last   = i_last;
                            n_state  = S_DICT;
                        end else begin
                            n_halted = 1'b1;
                            if (i_last) begin
                                n_ins     = '0;
                                n_halted  = 1'b0;
                                n_o_valid = 1'b1;
                                n_o_kind  = KIND_WORD;
                                n_o_score = '0;
                                n_o_nc    = NCOUNT_W'(r_nodes_used);
                                n_o_full  = r_over;
                                n_o_long  = 1'b0;
                            end
                        end
                    end else begin
                        if (cc.is_lower || cc.is_upper) begin
                            if (r_count < CW'(MAX_LEN)) begin
                                lb_we   = 1'b1;
                                n_count = r_count + CW'(1);
                            end else begin
                                n_trunc = 1'b1;
                            end
                        end
                        if (i_last) begin
                            if (n_count == '0) begin
                                n_o_valid = 1'b1;
                                n_o_kind  = KIND_CAND;
                                n_o_score = '0;
                                n_o_nc    = NCOUNT_W'(r_nodes_used);
                                n_o_full  = r_over;
                                n_o_long  = n_trunc;
                                n_trunc   = 1'b0;
                            end else begin
                                n_i     = '0;
                                n_j     = '0;
                                n_node  = '0;
                                n_sum   = '0;
                                n_state = S_WL;
                            end
                        end
                    end
                end
            end
            S_DICT: begin
                if (ct_rdata == '0) begin
                    if (r_nodes_used < UW'(NODES)) begin
                        ct_we        = 1'b1;
                        ct_wdata     = NW'(r_nodes_used);
                        n_ins        = NW'(r_nodes_used);
                        n_nodes_used = r_nodes_used + UW'(1);
                    end else begin
                        n_over   = 1'b1;
                        n_halted = 1'b1;
                    end
                end else begin
                    n_ins = ct_rdata;
                end
                if (r_last) begin
                    n_ins     = '0;
                    n_halted  = 1'b0;
                    n_o_valid = 1'b1;
                    n_o_kind  = KIND_WORD;
                    n_o_score = '0;
                    n_o_nc    = NCOUNT_W'(n_nodes_used);
                    n_o_full  = n_over;
                    n_o_long  = 1'b0;
                end
                n_state = S_IDLE;
            end
            S_WL: begin
                lb_raddr = r_j;
                n_state  = S_WC;
            end
            S_WC: begin
                n_caddr  = f_addr(r_node, lb_rdata);
                ct_raddr = n_caddr;
                n_state  = S_WN;
            end
            S_WN: begin
                if (ct_rdata == '0 || j_last) begin
                    n_sum = r_sum + SW'(r_j) - SW'(r_i);
                    if (i_is_last) begin
                        n_state = S_MUL;
                    end else begin
                        n_i      = r_i + BAW'(1);
                        n_j      = r_i + BAW'(1);
                        n_node   = '0;
                        lb_raddr = r_i + BAW'(1);
                        n_state  = S_WC;
                    end
                end else begin
                    n_node   = ct_rdata;
                    n_j      = r_j + BAW'(1);
                    lb_raddr = r_j + BAW'(1);
                    n_state  = S_WC;
                end
            end
            S_MUL: begin
                n_o_valid = 1'b1;
                n_o_kind  = KIND_CAND;
                n_o_score = SCORE_W'(SCORE_W'(r_sum) * SCORE_W'(r_count));
                n_o_nc    = NCOUNT_W'(r_nodes_used);
                n_o_full  = r_over;
                n_o_long  = r_trunc;
                n_count   = '0;
                n_trunc   = 1'b0;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_nodes_used <= UW'(1);
            r_ins        <= '0;
            r_halted     <= 1'b0;
            r_over       <= 1'b0;
            r_count      <= '0;
            r_trunc      <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            r_nodes_used <= n_nodes_used;
            r_ins        <= n_ins;
            r_halted     <= n_halted;
            r_over       <= n_over;
            r_count      <= n_count;
            r_trunc      <= n_trunc;
            r_o_valid    <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_caddr   <= n_caddr;
        r_last    <= n_last;
        r_i       <= n_i;
        r_j       <= n_j;
        r_node    <= n_node;
        r_sum     <= n_sum;
        r_o_kind  <= n_o_kind;
        r_o_score <= n_o_score;
        r_o_nc    <= n_o_nc;
        r_o_full  <= n_o_full;
        r_o_long  <= n_o_long;
    end

    assign o_valid       = r_o_valid;
    assign o_result_kind = r_o_kind;
    assign o_score       = r_o_score;
    assign o_node_count  = r_o_nc;
    assign o_table_full  = r_o_full;
    assign o_too_long    = r_o_long;

    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_ready)
        else $error("word accepted during clearing pass");

    a_nodes_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nodes_used <= UW'(NODES)) && (r_nodes_used != '0))
        else $error("node count out of range");

    a_word_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result_kind == KIND_WORD) |-> (o_score == '0 && !o_too_long))
        else $error("dictionary result carries candidate fields");

    a_walk_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WC || r_state == S_WN) |-> (r_i <= r_j && CW'(r_j) < r_count))
        else $error("walk indexes out of order");

    a_walk_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL || r_state == S_DICT) |-> !r_o_valid)
        else $error("result register busy when a result is produced");

endmodule

// ===== tb/trie_prefix_match_scorer_top_test.sv =====
// ----------------------------------------------------------------------------
// trie_prefix_match_scorer_top_test
// Self-checking bench for the prefix tree scorer: a queued driver feeds
// dictionary words and candidates with random gaps, a shadow tree predicts
// every word result and candidate score, and a monitor compares each
// result word in order against the expected one.
// ----------------------------------------------------------------------------
module trie_prefix_match_scorer_top_test;
    import tpm_pkg::*;

    localparam int NODES     = 4096;
    localparam int MAX_LEN   = 256;
    localparam int CYC_LIMIT = 4000000;

    typedef struct packed {
        logic       kind;
        logic [7:0] ch;
        logic       last;
    } t_item;

    typedef struct packed {
        logic                rkind;
        logic [SCORE_W-1:0]  score;
        logic [NCOUNT_W-1:0] ncount;
        logic                full;
        logic                toolong;
    } t_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic i_kind = 1'b0;
    logic [7:0] i_char_byte = 8'd0;
    logic i_last = 1'b0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic o_result_kind;
    logic [SCORE_W-1:0] o_score;
    logic [NCOUNT_W-1:0] o_node_count;
    logic o_table_full;
    logic o_too_long;

    trie_prefix_match_scorer_top #(.NODES(NODES), .MAX_LEN(MAX_LEN)) dut (.*);

    // shadow tree
    int unsigned kids [NODES*ALPHA];
    int unsigned used_nodes, cur_node;
    bit          halted, ovf, trunc;
    int unsigned letters [MAX_LEN];
    int unsigned nletters;

    t_item item_q [$];
    t_res  result_q [$];
    int    errors = 0;
    int    cycles = 0;
    bit    hold = 1'b0;
    bit    stim_done = 1'b0;
    int    send_wait = 0;
    int    recv_wait = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        errors++;
    endtask

    function automatic longint unsigned walk_score();
        longint unsigned sum;
        int unsigned node;
        sum = 0;
        for (int i = 0; i < nletters; i++) begin
            node = 0;
            for (int j = i; j < nletters; j++) begin
                node = kids[node*ALPHA + letters[j]];
                if (node == 0 || j == nletters - 1) begin
                    sum += j - i;
                    break;
                end
            end
        end
        return sum * nletters;
    endfunction

    task automatic predict(input t_item it);
        int unsigned slot, lt;
        t_res r;
        if (it.kind == KIND_WORD) begin
            if (!halted) begin
                if (it.ch < CH_LOWER_A || it.ch > CH_LOWER_Z) begin
                    halted = 1'b1;
                end else begin
                    slot = cur_node*ALPHA + (it.ch - CH_LOWER_A);
                    if (kids[slot] == 0) begin
                        if (used_nodes >= NODES) begin
                            ovf = 1'b1;
                            halted = 1'b1;
                        end else begin
                            kids[slot] = used_nodes;
                            used_nodes++;
                        end
                    end
                    if (!halted) cur_node = kids[slot];
                end
            end
        end else begin
            lt = 99;
            if (it.ch >= CH_LOWER_A && it.ch <= CH_LOWER_Z) lt = it.ch - CH_LOWER_A;
            else if (it.ch >= CH_UPPER_A && it.ch <= CH_UPPER_Z) lt = it.ch - CH_UPPER_A;
            if (lt != 99) begin
                if (nletters >= MAX_LEN) begin
                    trunc = 1'b1;
                end else begin
                    letters[nletters] = lt;
                    nletters++;
                end
            end
        end
        if (!it.last) return;
        r = '0;
        r.rkind = it.kind;
        if (it.kind == KIND_WORD) begin
            cur_node = 0;
            halted = 1'b0;
        end else begin
            r.score = SCORE_W'(walk_score());
            r.toolong = trunc;
            nletters = 0;
            trunc = 1'b0;
        end
        r.ncount = NCOUNT_W'(used_nodes);
        r.full = ovf;
        result_q.push_back(r);
    endtask

    function automatic logic [7:0] rand_letter(input bit upper_ok);
        if (upper_ok && $urandom_range(0, 3) == 0) return 8'(CH_UPPER_A + $urandom_range(0, 25));
        return 8'(CH_LOWER_A + $urandom_range(0, 25));
    endfunction

    task automatic add_seq(input logic kind, input int len, input int alpha_n, input int noise);
        t_item it;
        for (int k = 0; k < len; k++) begin
            it.kind = kind;
            it.ch = 8'(CH_LOWER_A + $urandom_range(0, alpha_n - 1));
            if (kind == KIND_CAND && $urandom_range(0, 3) == 0)
                it.ch = rand_letter(1'b1);
            if ($urandom_range(0, 99) < noise) it.ch = 8'($urandom_range(0, 255));
            it.last = (k == len - 1);
            item_q.push_back(it);
        end
    endtask

    task automatic add_one(input logic kind, input logic [7:0] ch, input logic last);
        t_item it;
        it.kind = kind;
        it.ch = ch;
        it.last = last;
        item_q.push_back(it);
    endtask

    // driver
    always @(posedge i_clk) begin
        t_item it;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                predict('{i_kind, i_char_byte, i_last});
                send_wait <= ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 19));
            end
            if ((!i_valid || o_ready) && !(i_valid && !o_ready)) begin
                if (send_wait > 0 && !(i_valid && o_ready)) begin
                    send_wait <= send_wait - 1;
                    i_valid <= 1'b0;
                end else if (!(i_valid && o_ready) && !hold && item_q.size() > 0) begin
                    it = item_q.pop_front();
                    i_valid <= 1'b1;
                    i_kind <= it.kind;
                    i_char_byte <= it.ch;
                    i_last <= it.last;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_res w;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (result_q.size() == 0) begin
                    report("unexpected word", o_score, 0);
                end else begin
                    w = result_q.pop_front();
                    if (o_result_kind !== w.rkind) report("result_kind", o_result_kind, w.rkind);
                    if (o_score !== w.score) report("score", o_score, w.score);
                    if (o_node_count !== w.ncount) report("node_count", o_node_count, w.ncount);
                    if (o_table_full !== w.full) report("table_full", o_table_full, w.full);
                    if (o_too_long !== w.toolong) report("too_long", o_too_long, w.toolong);
                end
                recv_wait = $urandom_range(0, 19);
                if ($urandom_range(0, 3) == 0) recv_wait = 0;
                i_ready <= (recv_wait == 0);
            end else if (recv_wait > 0) begin
                recv_wait--;
                i_ready <= (recv_wait == 0);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYC_LIMIT) begin
            $display("timeout");
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int len;
        used_nodes = 1;
        cur_node = 0;
        halted = 0;
        ovf = 0;
        trunc = 0;
        nletters = 0;
        foreach (kids[k]) kids[k] = 0;

        // directed
        add_one(KIND_CAND, 8'h00, 1'b1);
        add_seq(KIND_WORD, 3, 3, 0);
        add_one(KIND_WORD, 8'h61, 1'b0);
        add_one(KIND_WORD, 8'h7A, 1'b0);
        add_one(KIND_WORD, 8'h41, 1'b0);
        add_one(KIND_WORD, 8'h62, 1'b1);
        add_one(KIND_CAND, 8'h41, 1'b0);
        add_one(KIND_CAND, 8'h5A, 1'b0);
        add_one(KIND_CAND, 8'h7A, 1'b0);
        add_one(KIND_CAND, 8'hFF, 1'b0);
        add_one(KIND_CAND, 8'h61, 1'b0);
        add_one(KIND_WORD, 8'h80, 1'b1);
        add_one(KIND_CAND, 8'h20, 1'b1);
        add_one(KIND_CAND, 8'h61, 1'b1);

        for (int n = 0; n < 12; n++) begin
            @(posedge i_clk);
        end
        i_rst_n <= 1'b1;

        // random: words and candidates mixed evenly over a small alphabet
        while (item_q.size() < 300) begin
            len = $urandom_range(1, 8);
            if ($urandom_range(0, 1)) add_seq(KIND_WORD, len, 4, 5);
            else add_seq(KIND_CAND, $urandom_range(1, 14), 4, 10);
        end
        // one long candidate to truncate and grow the score
        add_seq(KIND_CAND, MAX_LEN + 6, 1, 0);
        while (item_q.size() > 0 || i_valid) @(posedge i_clk);
        hold = 1'b1;
        while (result_q.size() > 0) @(posedge i_clk);
        hold = 1'b0;
        // grow the tree with long random words
        for (int k = 0; k < 3; k++) add_seq(KIND_WORD, 20, 26, 0);
        for (int k = 0; k < 8; k++) begin
            add_seq(KIND_WORD, $urandom_range(1, 6), 26, 5);
            add_seq(KIND_CAND, $urandom_range(1, 12), 26, 10);
        end
        // wide letter distribution everywhere once
        for (int b = 0; b < 256; b += 4) add_one(KIND_CAND, b[7:0] | 8'($urandom_range(0, 3)), 1'b0);
        add_one(KIND_CAND, 8'h61, 1'b1);
        for (int b = 0; b < 256; b += 8) add_one(KIND_WORD, b[7:0] | 8'($urandom_range(0, 7)), 1'b1);

        while (item_q.size() > 0 || i_valid) @(posedge i_clk);
        while (result_q.size() > 0) @(posedge i_clk);
        for (int n = 0; n < 2000; n++) @(posedge i_clk);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
